/* sv/ugli_pkg.sv */
// Shared types and constants for the uniform grid LUT interpolator.
// No dependencies; imported by every module of the block.
package ugli_pkg;

	localparam int STEP_W = 16;
	localparam int DATA_W = 16;
	localparam int X_W    = 32;

	// configuration register indexes
	localparam logic [1:0] CFG_X_FIRST      = 2'd0;
	localparam logic [1:0] CFG_X_STEP       = 2'd1;
	localparam logic [1:0] CFG_TABLE_LENGTH = 2'd2;

	// lookup classes
	localparam logic [1:0] CLS_INTERP = 2'd0;
	localparam logic [1:0] CLS_BELOW  = 2'd1;
	localparam logic [1:0] CLS_ABOVE  = 2'd2;
	localparam logic [1:0] CLS_LAST   = 2'd3;

	// saturation bounds of the 16-bit output
	localparam logic signed [17:0] Y_SAT_HI = 18'sd32767;
	localparam logic signed [17:0] Y_SAT_LO = -18'sd32768;

	typedef struct packed {
		logic              cmd;
		logic signed [31:0] x_value;
		logic [5:0]        entry_index;
		logic signed [15:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] y_value;
		logic              outside_table;
	} out_item_t;

endpackage

/* sv/ugli_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on ugli_pkg for the divisor width.
module ugli_div_pipe #(
	parameter int DW = 32,
	parameter int PW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_valid,
	input  logic [DW-1:0]              in_dividend,
	input  logic [ugli_pkg::STEP_W-1:0] divisor,
	input  logic [PW-1:0]              in_payload,
	output logic                       out_valid,
	output logic [DW-1:0]              out_quot,
	output logic [ugli_pkg::STEP_W-1:0] out_rem,
	output logic [PW-1:0]              out_payload
);
	import ugli_pkg::*;

	logic              v_s   [DW+1];
	logic [DW-1:0]     n_s   [DW+1];
	logic [STEP_W-1:0] rem_s [DW+1];
	logic [PW-1:0]     pay_s [DW+1];

	always_comb begin
		v_s[0]   = in_valid;
		n_s[0]   = in_dividend;
		rem_s[0] = '0;
		pay_s[0] = in_payload;
	end

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [STEP_W:0] trial;
		logic [STEP_W:0] diff;
		logic            qbit;

		always_comb begin
			trial = {rem_s[k], n_s[k][DW-1]};
			diff  = trial - {1'b0, divisor};
			qbit  = (trial >= {1'b0, divisor});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= qbit ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
				n_s[k+1]   <= {n_s[k][DW-2:0], qbit};
				pay_s[k+1] <= pay_s[k];
			end
		end
	end

	assign out_valid   = v_s[DW];
	assign out_quot    = n_s[DW];
	assign out_rem     = rem_s[DW];
	assign out_payload = pay_s[DW];

endmodule

/* sv/ugli_table.sv */
// Table memory: one write port, two registered read ports.
// Depends on ugli_pkg for the entry width.
module ugli_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                       clk,
	input  logic                       adv,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ugli_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              raddr0,
	input  logic [AW-1:0]              raddr1,
	output logic [ugli_pkg::DATA_W-1:0] rdata0,
	output logic [ugli_pkg::DATA_W-1:0] rdata1
);
	import ugli_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

/* sv/uniform_grid_lut_interpolator_core.sv */
// Uniform grid lookup table with linear interpolation, top level.
// Path of a lookup: input register, two 32-stage dividers, table read, difference,
// multiply and output register. Write transactions give no result.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset (arst_n, async, low): config to x_first 0, step 1, length 1, pipeline empty.
// Table contents are not reset; entries are undefined until written.
module uniform_grid_lut_interpolator_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ugli_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ugli_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ugli_pkg::*;

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW1 = 1 + 1 + 6 + DATA_W;   // cmd, neg, index, value
	localparam int PW2 = 1 + 2 + DATA_W;       // diff sign, class, e0

	// ---------------- configuration ----------------
	logic [31:0]       x_first_q;
	logic [STEP_W-1:0] x_step_q;
	logic [6:0]        table_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_first_q      <= '0;
			x_step_q       <= STEP_W'(1);
			table_length_q <= 7'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_FIRST:      x_first_q      <= cfg_data;
				CFG_X_STEP:       x_step_q       <= cfg_data[STEP_W-1:0];
				CFG_TABLE_LENGTH: table_length_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// zero step acts as one; length clamped into 1..TABLE_DEPTH
	logic [STEP_W-1:0] step_eff;
	logic [31:0]       len_eff;
	logic [31:0]       last_idx;

	always_comb begin
		step_eff = (x_step_q == '0) ? STEP_W'(1) : x_step_q;
		if (table_length_q == 7'd0)
			len_eff = 32'd1;
		else if (32'(table_length_q) > 32'(TABLE_DEPTH))
			len_eff = 32'(TABLE_DEPTH);
		else
			len_eff = 32'(table_length_q);
		last_idx = len_eff - 32'd1;
	end

	// ---------------- global pipeline advance ----------------
	// Whole pipeline moves together; it holds only when the output register
	// has a result that the consumer is not taking.
	logic out_valid_q;
	logic adv;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// ---------------- stage 1: offset from first grid point ----------------
	logic              v_s1;
	logic              cmd_s1;
	logic              neg_s1;
	logic [31:0]       dmag_s1;
	logic [5:0]        idx_s1;
	logic [DATA_W-1:0] val_s1;
	logic [32:0]       d33;

	assign d33 = {in_data.x_value[31], in_data.x_value} - {x_first_q[31], x_first_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= in_data.cmd;
			neg_s1  <= d33[32];
			dmag_s1 <= d33[31:0];
			idx_s1  <= in_data.entry_index;
			val_s1  <= in_data.entry_value;
		end
	end

	// ---------------- divider 1: grid index and remainder ----------------
	// Write transactions ride along so that they reach the table in order
	// with the lookups around them.
	logic              v_a;
	logic [31:0]       quot_a;
	logic [STEP_W-1:0] rem_a;
	logic [PW1-1:0]    pay_a;

	ugli_div_pipe #(.DW(32), .PW(PW1)) u_div_idx (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (v_s1),
		.in_dividend(dmag_s1),
		.divisor    (step_eff),
		.in_payload ({cmd_s1, neg_s1, idx_s1, val_s1}),
		.out_valid  (v_a),
		.out_quot   (quot_a),
		.out_rem    (rem_a),
		.out_payload(pay_a)
	);

	logic              cmd_a;
	logic              neg_a;
	logic [5:0]        idx_a;
	logic [DATA_W-1:0] val_a;

	assign {cmd_a, neg_a, idx_a, val_a} = pay_a;

	// ---------------- classify and table access ----------------
	logic [1:0]    cls_a;
	logic [AW-1:0] raddr0;
	logic [AW-1:0] raddr1;
	logic          we_a;

	always_comb begin
		if (neg_a)
			cls_a = CLS_BELOW;
		else if (quot_a > last_idx)
			cls_a = CLS_ABOVE;
		else if (quot_a == last_idx)
			cls_a = CLS_LAST;
		else
			cls_a = CLS_INTERP;

		case (cls_a)
			CLS_BELOW:            raddr0 = '0;
			CLS_ABOVE, CLS_LAST:  raddr0 = last_idx[AW-1:0];
			default:              raddr0 = quot_a[AW-1:0];
		endcase
		raddr1 = quot_a[AW-1:0] + AW'(1);
		// out-of-range writes are dropped
		we_a   = v_a && cmd_a && (32'(idx_a) < 32'(TABLE_DEPTH));
	end

	logic [DATA_W-1:0] e0_rd;
	logic [DATA_W-1:0] e1_rd;

	ugli_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk   (clk),
		.adv   (adv),
		.we    (we_a),
		.waddr (AW'(idx_a)),
		.wdata (val_a),
		.raddr0(raddr0),
		.raddr1(raddr1),
		.rdata0(e0_rd),
		.rdata1(e1_rd)
	);

	// stage 2: aligned with the registered table read data
	logic              v_s2;
	logic [1:0]        cls_s2;
	logic [STEP_W-1:0] r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_a && !cmd_a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s2 <= cls_a;
			r_s2   <= rem_a;
		end
	end

	// ---------------- stage 3: neighbor difference ----------------
	logic signed [16:0] diff;
	logic               v_s3;
	logic [1:0]         cls_s3;
	logic [STEP_W-1:0]  r_s3;
	logic               dneg_s3;
	logic [15:0]        dmag_s3;
	logic [DATA_W-1:0]  e0_s3;

	assign diff = {e1_rd[DATA_W-1], e1_rd} - {e0_rd[DATA_W-1], e0_rd};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s3  <= cls_s2;
			r_s3    <= r_s2;
			dneg_s3 <= diff[16];
			dmag_s3 <= diff[16] ? 16'(-diff) : diff[15:0];
			e0_s3   <= e0_rd;
		end
	end

	// ---------------- stage 4: remainder times difference ----------------
	logic              v_s4;
	logic [1:0]        cls_s4;
	logic              dneg_s4;
	logic [31:0]       prod_s4;
	logic [DATA_W-1:0] e0_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s4  <= cls_s3;
			dneg_s4 <= dneg_s3;
			prod_s4 <= 32'(r_s3) * 32'(dmag_s3);
			e0_s4   <= e0_s3;
		end
	end

	// ---------------- divider 2: scale by step ----------------
	// Magnitude division, so the quotient truncates toward zero.
	logic              v_b;
	logic [31:0]       q_b;
	logic [STEP_W-1:0] rem_b;
	logic [PW2-1:0]    pay_b;

	ugli_div_pipe #(.DW(32), .PW(PW2)) u_div_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (v_s4),
		.in_dividend(prod_s4),
		.divisor    (step_eff),
		.in_payload ({dneg_s4, cls_s4, e0_s4}),
		.out_valid  (v_b),
		.out_quot   (q_b),
		.out_rem    (rem_b),
		.out_payload(pay_b)
	);

	logic              dneg_b;
	logic [1:0]        cls_b;
	logic [DATA_W-1:0] e0_b;

	assign {dneg_b, cls_b, e0_b} = pay_b;

	// ---------------- result and output register ----------------
	// quotient stays below 2^16, so 18 signed bits hold e0 +/- q
	logic signed [17:0] qs;
	logic signed [17:0] ysum;
	out_item_t          res;
	out_item_t          out_data_q;

	always_comb begin
		qs   = $signed({1'b0, q_b[16:0]});
		ysum = $signed({{2{e0_b[DATA_W-1]}}, e0_b}) + (dneg_b ? -qs : qs);
		res.outside_table = (cls_b == CLS_BELOW) || (cls_b == CLS_ABOVE);
		if (cls_b != CLS_INTERP)
			res.y_value = e0_b;
		else if (ysum > Y_SAT_HI)
			res.y_value = Y_SAT_HI[15:0];
		else if (ysum < Y_SAT_LO)
			res.y_value = Y_SAT_LO[15:0];
		else
			res.y_value = ysum[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_b;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// remainder of the scale divide is not part of the result
	logic unused_rem;
	assign unused_rem = ^{rem_b, q_b[31:17]};

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for uniform_grid_lut_interpolator_core.
// Depends on ugli_pkg and the core; predicts each lookup result and checks it in order.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ugli_pkg::*;

	localparam int DEPTH     = 64;
	localparam int LATENCY   = 69;
	localparam int LIMIT_CYC = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	uniform_grid_lut_interpolator_core #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: its own copy of the configuration and table
	logic signed [31:0] grid_origin;
	logic [15:0]        grid_spacing;
	logic [6:0]         used_entries;
	logic signed [15:0] lut_shadow [DEPTH];
	bit                 lut_written [DEPTH];

	out_item_t   pending_y [$];
	int          err_count;
	int          lookup_count;
	int          result_count;
	int          cycle_count;
	bit          quiet_in;      // no idling on the input side
	bit          quiet_out;     // no stalling on the output side

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// exact interpolation, mirrors the lookup rule in 64-bit arithmetic
	function automatic out_item_t interpolate(input logic signed [31:0] x);
		out_item_t        o;
		longint           d, step, len, idx, rem, e0, e1, prod, q, y;
		step = (grid_spacing == 0) ? 1 : grid_spacing;
		len  = (used_entries == 0) ? 1 : used_entries;
		if (len > DEPTH) len = DEPTH;
		d = longint'(x) - longint'(grid_origin);
		o.outside_table = 1'b0;
		if (d < 0) begin
			o.y_value = lut_shadow[0];
			o.outside_table = 1'b1;
			return o;
		end
		idx = d / step;
		rem = d % step;
		if (idx >= len - 1) begin
			o.y_value = lut_shadow[len-1];
			o.outside_table = (idx > len - 1);
			return o;
		end
		e0   = lut_shadow[idx];
		e1   = lut_shadow[idx+1];
		prod = rem * (e1 - e0);
		q    = prod / step;   // SV division truncates toward zero
		y    = e0 + q;
		if (y > 32767) y = 32767;
		if (y < -32768) y = -32768;
		o.y_value = y[15:0];
		return o;
	endfunction

	// true if the lookup only touches written entries
	function automatic bit lookup_is_safe(input logic signed [31:0] x);
		longint d, step, len, idx;
		step = (grid_spacing == 0) ? 1 : grid_spacing;
		len  = (used_entries == 0) ? 1 : used_entries;
		if (len > DEPTH) len = DEPTH;
		d = longint'(x) - longint'(grid_origin);
		if (d < 0) return lut_written[0];
		idx = d / step;
		if (idx >= len - 1) return lut_written[len-1];
		return lut_written[idx] && lut_written[idx+1];
	endfunction

	// one transaction on the input channel, with random idling before it;
	// valid stays high after acceptance so items can follow back to back
	task automatic send_item(input in_item_t item);
		while (!quiet_in && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge: update the predictor
		if (item.cmd) begin
			lut_shadow[item.entry_index]  = item.entry_value;
			lut_written[item.entry_index] = 1'b1;
		end else begin
			pending_y.push_back(interpolate(item.x_value));
			lookup_count++;
		end
	endtask

	task automatic write_entry(input int idx, input logic signed [15:0] val);
		in_item_t it;
		it = '0;
		it.cmd = 1'b1;
		it.entry_index = idx[5:0];
		it.entry_value = val;
		it.x_value = $urandom;
		send_item(it);
	endtask

	task automatic look_up(input logic signed [31:0] x);
		in_item_t it;
		it = '0;
		it.cmd = 1'b0;
		it.x_value = x;
		it.entry_index = 6'($urandom);
		it.entry_value = 16'($urandom);
		if (lookup_is_safe(x)) send_item(it);
	endtask

	// stop sending and wait until the pipeline is empty
	task automatic drain;
		in_valid <= 1'b0;
		while (pending_y.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_X_FIRST:      grid_origin  = val;
			CFG_X_STEP:       grid_spacing = val[15:0];
			CFG_TABLE_LENGTH: used_entries = val[6:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic signed [31:0] org, input int spc, input int len);
		drain();
		set_reg(CFG_X_FIRST, org);
		set_reg(CFG_X_STEP, spc);
		set_reg(CFG_TABLE_LENGTH, len);
		cfg_we <= 1'b0;
	endtask

	task automatic fill_table(input bit extremes);
		for (int i = 0; i < DEPTH; i++) begin
			if (extremes) write_entry(i, (i % 2) ? 16'sh7fff : 16'sh8000);
			else write_entry(i, 16'($urandom));
		end
	endtask

	// reset defaults, extremes of x_value, entries at both extremes
	task automatic test_directed;
		write_entry(0, 16'sh1234);
		look_up(32'sh0);
		look_up(32'sh7fffffff);
		look_up(32'sh80000000);
		fill_table(1'b1);
		set_grid(32'sh80000000, 65535, 64);
		look_up(32'sh80000000);           // first point
		look_up(32'sh80000000 + 32767);   // half step, full swing
		look_up(32'sh80000000 + 65534);
		look_up(32'sh7fffffff);           // far past the table
		set_grid(32'sh7fffffff, 1, 64);
		look_up(32'sh80000000);           // below, huge negative distance
		look_up(32'sh7fffffff);
		set_grid(-100, 10, 4);
		look_up(-101);
		look_up(-71);                     // in the last cell, not past it
		look_up(-70);                     // exactly the last point
		look_up(-61);                     // just past it
		look_up(-95);
		set_grid(0, 3, 2);
		look_up(1);
		look_up(2);
		write_entry(0, -5);
		write_entry(1, 5);
		look_up(1);                       // truncation of a positive product
		look_up(2);
	endtask

	// random writes and lookups across random grid settings
	task automatic test_random(input int n_items);
		in_item_t it;
		int       mode;
		longint   span;
		for (int i = 0; i < n_items; i++) begin
			if (i % 200 == 0) begin
				mode = $urandom_range(3);
				case (mode)
					0: set_grid($urandom, $urandom_range(1, 65535), $urandom_range(1, 64));
					1: set_grid($urandom_range(2000) - 1000, $urandom_range(1, 8),
						$urandom_range(2, 64));
					2: set_grid($urandom, 65535, 64);
					default: set_grid(-($urandom_range(100000)), $urandom_range(1, 300),
						$urandom_range(1, 10));
				endcase
				quiet_in  = (i % 600 == 400);
				quiet_out = quiet_in;
			end
			if ($urandom_range(9) < 2) begin
				write_entry($urandom_range(63), $urandom_range(1) ? 16'($urandom) :
					($urandom_range(1) ? 16'sh7fff : 16'sh8000));
			end else begin
				span = longint'(grid_spacing) * (used_entries + 1);
				if ($urandom_range(9) < 8)
					look_up(grid_origin + $signed(32'($urandom % (span + 2))) - 1);
				else
					look_up($urandom);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t exp_y;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (out_valid && out_ready) begin
				if (pending_y.size() == 0) begin
					$display("%0t: unexpected result y=%0d flag=%0b", $time,
						out_data.y_value, out_data.outside_table);
					err_count++;
				end else begin
					exp_y = pending_y.pop_front();
					result_count++;
					if (out_data.y_value !== exp_y.y_value)
						$display("%0t: y_value expected %0d actual %0d", $time,
							exp_y.y_value, out_data.y_value);
					if (out_data.outside_table !== exp_y.outside_table)
						$display("%0t: outside_table expected %0b actual %0b", $time,
							exp_y.outside_table, out_data.outside_table);
					if (out_data !== exp_y) err_count++;
				end
			end
			out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 21);
			if (cycle_count > LIMIT_CYC) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_X_FIRST;
		cfg_data = '0;
		err_count = 0;
		lookup_count = 0;
		result_count = 0;
		cycle_count = 0;
		quiet_in = 1'b0;
		quiet_out = 1'b0;
		grid_origin = 0;
		grid_spacing = 1;
		used_entries = 1;
		for (int i = 0; i < DEPTH; i++) begin
			lut_shadow[i] = '0;
			lut_written[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		fill_table(1'b0);
		test_random(1400);
		drain();
		$display("covered %0d lookups, %0d results checked, grids from step 1 to 65535",
			lookup_count, result_count);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
